### hdl/cqp_pkg.sv
// Shared types, widths and constants for the complex 4-bit quantiser and packetiser.
`default_nettype none

package cqp_pkg;

    localparam int ADDR_BITS_DEF    = 24;
    localparam int HEADER_BYTES_DEF = 32;

    localparam int SAMPLE_W     = 20;
    localparam int SCALE_W      = 16;
    localparam int BYTE_ADDR_W  = 24;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [11:0] SPP_RST       = 12'd3125;
    localparam logic [7:0]  PPB_RST       = 8'd16;
    localparam logic [13:0] PKT_BYTES_RST = 14'd6288;
    localparam logic [4:0]  BEAM_RST      = 5'd10;
    localparam logic [1:0]  POL_RST       = 2'd2;
    localparam logic [3:0]  STREAM_RST    = 4'd4;

    localparam logic [7:0] PPB_MAX    = 8'd128;
    localparam logic [4:0] BEAM_MAX   = 5'd16;
    localparam logic [1:0] POL_MAX    = 2'd2;
    localparam logic [3:0] STREAM_MAX = 4'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LAYOUT_MODE  = 3'd0,
        REG_SPP          = 3'd1,
        REG_PPB          = 3'd2,
        REG_PACKET_BYTES = 3'd3,
        REG_BEAM_COUNT   = 3'd4,
        REG_POL_COUNT    = 3'd5,
        REG_STREAM_COUNT = 3'd6
    } cqp_reg_e;

    // effective (range limited) configuration
    typedef struct packed {
        logic        layout_mode;
        logic [11:0] spp;
        logic [7:0]  ppb;
        logic [13:0] packet_bytes;
        logic [4:0]  nb;
        logic [1:0]  np;
        logic [3:0]  ns;
    } cqp_cfg_t;

    typedef struct packed {
        logic [BYTE_ADDR_W-1:0]    addr;
        logic                      done;
        logic signed [SAMPLE_W-1:0] real_value;
        logic signed [SAMPLE_W-1:0] imag_value;
        logic [SCALE_W-1:0]        scale;
    } cqp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cqp_qstat_t;

endpackage

`default_nettype wire

### hdl/cqp_cfg.sv
// Configuration register file with range limiting of the count registers.
`default_nettype none

module cqp_cfg
    import cqp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cqp_cfg_t               cfg
);

    logic        layout_reg;
    logic [11:0] spp_reg;
    logic [7:0]  ppb_reg;
    logic [13:0] pkt_bytes_reg;
    logic [4:0]  beam_reg;
    logic [1:0]  pol_reg;
    logic [3:0]  stream_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg    <= 1'b0;
            spp_reg       <= SPP_RST;
            ppb_reg       <= PPB_RST;
            pkt_bytes_reg <= PKT_BYTES_RST;
            beam_reg      <= BEAM_RST;
            pol_reg       <= POL_RST;
            stream_reg    <= STREAM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LAYOUT_MODE:  layout_reg    <= cfg_data[0];
                REG_SPP:          spp_reg       <= cfg_data[11:0];
                REG_PPB:          ppb_reg       <= cfg_data[7:0];
                REG_PACKET_BYTES: pkt_bytes_reg <= cfg_data[13:0];
                REG_BEAM_COUNT:   beam_reg      <= cfg_data[4:0];
                REG_POL_COUNT:    pol_reg       <= cfg_data[1:0];
                REG_STREAM_COUNT: stream_reg    <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // zero counts act as one, oversize counts saturate
    always_comb
    begin
        cfg.layout_mode  = layout_reg;
        cfg.packet_bytes = pkt_bytes_reg;
        cfg.spp = (spp_reg == 12'd0) ? 12'd1 : spp_reg;
        cfg.ppb = (ppb_reg == 8'd0) ? 8'd1 : ((ppb_reg > PPB_MAX) ? PPB_MAX : ppb_reg);
        cfg.nb  = (beam_reg == 5'd0) ? 5'd1 : ((beam_reg > BEAM_MAX) ? BEAM_MAX : beam_reg);
        cfg.np  = (pol_reg == 2'd0) ? 2'd1 : ((pol_reg > POL_MAX) ? POL_MAX : pol_reg);
        cfg.ns  = (stream_reg == 4'd0) ? 4'd1
                : ((stream_reg > STREAM_MAX) ? STREAM_MAX : stream_reg);
    end

endmodule

`default_nettype wire

### hdl/cqp_queue.sv
// Short request queue between the address front end and the quantiser.
`default_nettype none

module cqp_queue
    import cqp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  cqp_item_t  push_item,
    input  logic       pop,
    output cqp_item_t  head,
    output cqp_qstat_t qstat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cqp_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("request pushed into full queue");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !qstat.empty)
        else $error("queue empty after a lone push");

endmodule

`default_nettype wire

### hdl/cqp_front.sv
// Front end: accepts samples, walks the sample counters and works out the byte address.
`default_nettype none

module cqp_front
    import cqp_pkg::*;
#(
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cqp_cfg_t              cfg,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  cqp_qstat_t            qstat,
    output logic                  push,
    output cqp_item_t             push_item
);

    localparam int KEEP_BITS = (ADDR_BITS < BYTE_ADDR_W) ? ADDR_BITS : BYTE_ADDR_W;
    localparam logic [BYTE_ADDR_W-1:0] ADDR_MASK =
        BYTE_ADDR_W'((64'd1 << KEEP_BITS) - 64'd1);

    typedef enum logic [1:0] {F_IDLE, F_MUL1, F_MUL2, F_PUSH} front_state_t;

    front_state_t state_reg;

    logic        pol_reg;
    logic [3:0]  beam_reg;
    logic [2:0]  stream_reg;
    logic [11:0] time_reg;
    logic [6:0]  packet_reg;

    logic        pol_next;
    logic [3:0]  beam_next;
    logic [2:0]  stream_next;
    logic [11:0] time_next;
    logic [6:0]  packet_next;

    logic [1:0]  pol_inc;
    logic [4:0]  beam_inc;
    logic [3:0]  stream_inc;
    logic [12:0] time_inc;
    logic [7:0]  packet_inc;
    logic        pol_wrap, beam_wrap, stream_wrap, time_wrap, packet_wrap;
    logic        done_now;

    logic signed [SAMPLE_W-1:0] real_reg;
    logic signed [SAMPLE_W-1:0] imag_reg;
    logic [SCALE_W-1:0]         scale_reg;

    logic [7:0]  a_reg, a_next;
    logic [16:0] b_reg, b_next;
    logic [16:0] a2_reg, a2_next;
    logic [18:0] b2_reg, b2_next;
    logic [31:0] addr_sum;
    logic        accept;

    assign s_axis_tready = (state_reg == F_IDLE);
    assign accept        = s_axis_tvalid && (state_reg == F_IDLE);
    assign push          = (state_reg == F_PUSH) && !qstat.full;

    always_comb
    begin
        pol_inc     = {1'b0, pol_reg} + 2'd1;
        beam_inc    = {1'b0, beam_reg} + 5'd1;
        stream_inc  = {1'b0, stream_reg} + 4'd1;
        time_inc    = {1'b0, time_reg} + 13'd1;
        packet_inc  = {1'b0, packet_reg} + 8'd1;
        pol_wrap    = pol_inc >= cfg.np;
        beam_wrap   = beam_inc >= cfg.nb;
        stream_wrap = stream_inc >= cfg.ns;
        time_wrap   = time_inc >= {1'b0, cfg.spp};
        packet_wrap = packet_inc >= cfg.ppb;

        pol_next    = pol_wrap ? 1'b0 : pol_inc[0];
        beam_next   = !pol_wrap ? beam_reg : (beam_wrap ? 4'd0 : beam_inc[3:0]);
        stream_next = !(pol_wrap && beam_wrap) ? stream_reg
                    : (stream_wrap ? 3'd0 : stream_inc[2:0]);
        time_next   = !(pol_wrap && beam_wrap && stream_wrap) ? time_reg
                    : (time_wrap ? 12'd0 : time_inc[11:0]);
        packet_next = !(pol_wrap && beam_wrap && stream_wrap && time_wrap) ? packet_reg
                    : (packet_wrap ? 7'd0 : packet_inc[6:0]);
        done_now    = pol_wrap && beam_wrap && stream_wrap && time_wrap && packet_wrap;
    end

    // address in three multiply steps
    always_comb
    begin
        if (cfg.layout_mode)
        begin
            a_next = 8'(beam_reg);
            b_next = 17'(17'(time_reg) * 17'(cfg.ns)) + 17'(stream_reg);
        end
        else
        begin
            a_next = 8'(8'(stream_reg) * 8'(cfg.nb)) + 8'(beam_reg);
            b_next = 17'(time_reg);
        end
        a2_next  = 17'(17'(a_reg) * 17'(cfg.ppb)) + 17'(packet_reg);
        b2_next  = 19'(19'(b_reg) * 19'(cfg.np)) + 19'(pol_reg);
        addr_sum = 32'(32'(a2_reg) * 32'(cfg.packet_bytes)) + 32'(b2_reg)
                 + 32'(HEADER_BYTES);

        push_item.addr       = addr_sum[BYTE_ADDR_W-1:0] & ADDR_MASK;
        push_item.done       = done_now;
        push_item.real_value = real_reg;
        push_item.imag_value = imag_reg;
        push_item.scale      = scale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_MUL1;
                    end
                end
                F_MUL1:  state_reg <= F_MUL2;
                F_MUL2:  state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (!qstat.full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // counters step once the request is queued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg    <= 1'b0;
            beam_reg   <= '0;
            stream_reg <= '0;
            time_reg   <= '0;
            packet_reg <= '0;
        end
        else if (push)
        begin
            pol_reg    <= pol_next;
            beam_reg   <= beam_next;
            stream_reg <= stream_next;
            time_reg   <= time_next;
            packet_reg <= packet_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            real_reg  <= s_axis_tdata[19:0];
            imag_reg  <= s_axis_tdata[39:20];
            scale_reg <= s_axis_tdata[55:40];
        end
        if (state_reg == F_MUL1)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (state_reg == F_MUL2)
        begin
            a2_reg <= a2_next;
            b2_reg <= b2_next;
        end
    end

    a_count_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        !push |=> $stable(time_reg) && $stable(packet_reg) && $stable(pol_reg))
        else $error("sample counters moved without a queued request");

endmodule

`default_nettype wire

### hdl/cqp_back.sv
// Back end: serial quantiser for both parts, nibble packing and output register.
`default_nettype none

module cqp_back
    import cqp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cqp_item_t              head,
    input  cqp_qstat_t             qstat,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam logic [2:0] SAT_STEP = 3'd4;

    typedef enum logic [1:0] {B_IDLE, B_RUN, B_WAIT} back_state_t;

    back_state_t state_reg;
    logic [2:0]  step_reg;

    logic [24:0] rem_re_reg, rem_im_reg;
    logic [28:0] dsh_reg;
    logic        neg_re_reg, neg_im_reg;
    logic        sat_re_reg, sat_im_reg;
    logic [3:0]  q_re_reg, q_im_reg;
    logic [BYTE_ADDR_W-1:0] addr_reg;
    logic        done_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_last_reg;

    logic [SCALE_W-1:0] s_eff;
    logic [25:0]        n_re, n_im;
    logic [24:0]        mag_re, mag_im;
    logic               ge_re, ge_im;
    logic               load_out;
    logic [7:0]         packed_byte;

    function automatic logic [3:0] to_nibble(input logic neg, input logic sat,
                                             input logic [3:0] q);
        logic [3:0] mag;
        mag = sat ? 4'd15 : q;
        if (!neg)
        begin
            return (mag >= 4'd7) ? 4'd15 : mag + 4'd8;
        end
        return (mag >= 4'd8) ? 4'd0 : 4'd8 - mag;
    endfunction

    assign pop           = (state_reg == B_IDLE) && !qstat.empty;
    assign load_out      = (state_reg == B_WAIT) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // n = 2v + 256s against d = 512s, sign and magnitude kept apart
    always_comb
    begin
        s_eff  = (head.scale == '0) ? 16'd1 : head.scale;
        n_re   = {{5{head.real_value[19]}}, head.real_value, 1'b0} + {2'b00, s_eff, 8'd0};
        n_im   = {{5{head.imag_value[19]}}, head.imag_value, 1'b0} + {2'b00, s_eff, 8'd0};
        mag_re = n_re[25] ? 25'(-n_re) : n_re[24:0];
        mag_im = n_im[25] ? 25'(-n_im) : n_im[24:0];
        ge_re  = {4'd0, rem_re_reg} >= dsh_reg;
        ge_im  = {4'd0, rem_im_reg} >= dsh_reg;
        packed_byte = {to_nibble(neg_re_reg, sat_re_reg, q_re_reg),
                       to_nibble(neg_im_reg, sat_im_reg, q_im_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && !load_out)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= B_RUN;
                        step_reg  <= SAT_STEP;
                    end
                end
                B_RUN:
                begin
                    if (step_reg == 3'd0)
                    begin
                        state_reg <= B_WAIT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 3'd1;
                    end
                end
                B_WAIT:
                begin
                    if (load_out)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {packed_byte, addr_reg};
                        m_last_reg  <= done_reg;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // first step only checks for a quotient of 16 or more, then four restoring steps
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_re_reg <= mag_re;
            rem_im_reg <= mag_im;
            neg_re_reg <= n_re[25];
            neg_im_reg <= n_im[25];
            dsh_reg    <= {s_eff, 13'd0};
            q_re_reg   <= '0;
            q_im_reg   <= '0;
            addr_reg   <= head.addr;
            done_reg   <= head.done;
        end
        else if (state_reg == B_RUN)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (step_reg == SAT_STEP)
            begin
                sat_re_reg <= ge_re;
                sat_im_reg <= ge_im;
            end
            else
            begin
                q_re_reg <= {q_re_reg[2:0], ge_re};
                q_im_reg <= {q_im_reg[2:0], ge_im};
                if (ge_re)
                begin
                    rem_re_reg <= rem_re_reg - dsh_reg[24:0];
                end
                if (ge_im)
                begin
                    rem_im_reg <= rem_im_reg - dsh_reg[24:0];
                end
            end
        end
    end

    a_pop_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_RUN) && (step_reg == SAT_STEP))
        else $error("quantiser did not start after taking a request");

    a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == B_WAIT)
        else $error("output loaded outside the wait state");

endmodule

`default_nettype wire

### hdl/complex_4bit_quantizer_packetizer.sv
// Top level of the complex 4-bit quantiser and payload packetiser.
`default_nettype none

// Takes one complex sample per request in time, stream, beam, polarisation order,
// quantises each part to a 4-bit offset-binary nibble (divide by 256 times scale, add
// one half and truncate toward zero, add 8, clamp to 0..15) and returns the packed byte
// with its byte offset in the packet buffer and a flag on the buffer's last byte. The
// front end steps through accept, two multiply steps and a queue write per sample; the
// back end through queue read, a saturation check and four compare-subtract steps of
// the serial quantiser, and output load, so the quantiser sets the throughput. A
// two-entry queue lets the front end take the next sample while the quantiser or
// output is busy. Configuration writes take effect at once and do not reset the
// sample counters.
module complex_4bit_quantizer_packetizer
    import cqp_pkg::*;
#(
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // real_value, imag_value, scale
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // byte_address, packed_byte
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cqp_cfg_t   cfg;
    cqp_qstat_t qstat;
    cqp_item_t  push_item;
    cqp_item_t  head;
    logic       push;
    logic       pop;

    cqp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cqp_front #(
        .ADDR_BITS    (ADDR_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    cqp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    cqp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
